// File: design/sprite_blit_led_matrix_macros.svh
// Assertion macros shared by the sprite blitter modules.
`ifndef SPRITE_BLIT_LED_MATRIX_MACROS_SVH
`define SPRITE_BLIT_LED_MATRIX_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define SBL_ASSERT_NOW(label, clk_i, rst_ni, ante, cons) \
    label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
        else $error("sprite blitter assertion failed");

// Next-cycle implication, held off while reset is asserted.
`define SBL_ASSERT_NEXT(label, clk_i, rst_ni, ante, cons) \
    label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
        else $error("sprite blitter assertion failed");

`endif

// File: design/sbl_pkg.sv
// Shared constants and types of the sprite blitter.
package sbl_pkg;

    localparam int SCREEN_COLUMNS = 16;
    localparam int SCREEN_ROWS    = 8;
    localparam int LED_COUNT      = SCREEN_COLUMNS * SCREEN_ROWS;

    localparam int LED_W   = 7;
    localparam int X_W     = $clog2(SCREEN_COLUMNS);
    localparam int Y_W     = $clog2(SCREEN_ROWS);
    localparam int CODE_W  = 3;
    localparam int COLOR_W = 24;
    localparam int ANCHOR_W = 6;
    localparam int SIZE_W  = 5;
    localparam int CNT_W   = 4;
    localparam int COORD_W = 8;
    localparam int MAX_SIZE = 16;

    localparam int PAL_N     = 8;
    localparam int PAL_REGS  = 7;
    localparam int CFG_IDX_W = 3;

    localparam logic [CODE_W-1:0]    CODE_BLACK        = 3'd7;
    localparam logic [CODE_W-1:0]    TRANSPARENT_RESET = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_0     = 3'd1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    typedef logic [PAL_N-1:0][COLOR_W-1:0] palette_t;

    // One drawable pixel on its way from the front to the back.
    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [X_W-1:0]     x;
        logic [Y_W-1:0]     y;
        logic               ovr_en;
        logic [COLOR_W-1:0] ovr_color;
    } pix_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

// File: design/sprite_blit_led_matrix.sv
// Top level of the sprite blitter for the 16x8 LED matrix.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+------------------------------------------
//   pixels   | in        | push / full          | pixel_code, first_pixel, anchor_x/y,
//            |           |                      | sprite_width/height, mirror,
//            |           |                      | use_override, override_color
//   LEDs     | out       | pop / empty          | led_index, led_color
//   config   | in        | cfg_we (no wait)     | cfg_index, cfg_data
//
// One pixel is taken per cycle whenever full is low; the queue and the
// result register let a new pixel enter while an older result waits.
// A drawable pixel is written into the queue at its transfer and moves on into
// the result register once that register is free or being taken, where it
// waits until it is taken; dropped pixels leave no trace.
// full rises only when the four-entry queue and the result register are
// all occupied, i.e. when the consumer holds pop low while pixels keep arriving.
// Reset (rst_n low, asynchronous) clears the counters, sets a 1x1 sprite at
// 0,0, transparent code 7 and an all-black palette.
module sprite_blit_led_matrix
    import sbl_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    // pixel input
    input  logic                        push,
    output logic                        full,
    input  logic [CODE_W-1:0]           pixel_code,
    input  logic                        first_pixel,
    input  logic signed [ANCHOR_W-1:0]  anchor_x,
    input  logic signed [ANCHOR_W-1:0]  anchor_y,
    input  logic [SIZE_W-1:0]           sprite_width,
    input  logic [SIZE_W-1:0]           sprite_height,
    input  logic                        mirror,
    input  logic                        use_override,
    input  logic [COLOR_W-1:0]          override_color,
    // LED output
    output logic                        empty,
    input  logic                        pop,
    output logic [LED_W-1:0]            led_index,
    output logic [COLOR_W-1:0]          led_color,
    // configuration writes
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [COLOR_W-1:0]          cfg_data
);

    logic [CODE_W-1:0]  transparent_code_reg;
    logic [COLOR_W-1:0] palette_reg [PAL_REGS];
    palette_t           palette;

    q_stat_t q_stat;
    logic    q_push, q_pop;
    pix_t    q_wdata, q_rdata;

    // Register 0 is the transparent code, registers 1..7 the palette.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            transparent_code_reg <= TRANSPARENT_RESET;
            for (int i = 0; i < PAL_REGS; i++)
                palette_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_TRANSPARENT)
                transparent_code_reg <= cfg_data[CODE_W-1:0];
            for (int i = 0; i < PAL_REGS; i++)
                if (cfg_index == CFG_IDX_W'(REG_PALETTE_0 + CFG_IDX_W'(i)))
                    palette_reg[i] <= cfg_data;
        end
    end

    // Code 7 has no register: it always draws black.
    always_comb
    begin
        for (int i = 0; i < PAL_REGS; i++)
            palette[i] = palette_reg[i];
        palette[CODE_BLACK] = '0;
    end

    assign full = q_stat.full;

    sbl_front u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .pixel_code       (pixel_code),
        .first_pixel      (first_pixel),
        .anchor_x         (anchor_x),
        .anchor_y         (anchor_y),
        .sprite_width     (sprite_width),
        .sprite_height    (sprite_height),
        .mirror           (mirror),
        .use_override     (use_override),
        .override_color   (override_color),
        .transparent_code (transparent_code_reg),
        .q_stat           (q_stat),
        .q_push           (q_push),
        .q_data           (q_wdata)
    );

    sbl_fifo u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    sbl_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .palette   (palette),
        .pop       (pop),
        .empty     (empty),
        .led_index (led_index),
        .led_color (led_color)
    );

endmodule

// File: design/sbl_front.sv
// Front end: geometry latch, stored-order counters and pixel classification.
module sbl_front
    import sbl_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [CODE_W-1:0]          pixel_code,
    input  logic                       first_pixel,
    input  logic signed [ANCHOR_W-1:0] anchor_x,
    input  logic signed [ANCHOR_W-1:0] anchor_y,
    input  logic [SIZE_W-1:0]          sprite_width,
    input  logic [SIZE_W-1:0]          sprite_height,
    input  logic                       mirror,
    input  logic                       use_override,
    input  logic [COLOR_W-1:0]         override_color,
    input  logic [CODE_W-1:0]          transparent_code,
    input  q_stat_t                    q_stat,
    output logic                       q_push,
    output pix_t                       q_data
);

    localparam logic signed [COORD_W-1:0] X_LIM = COORD_W'(SCREEN_COLUMNS);
    localparam logic signed [COORD_W-1:0] Y_LIM = COORD_W'(SCREEN_ROWS);

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > SIZE_W'(MAX_SIZE))
            r = SIZE_W'(MAX_SIZE);
        return r;
    endfunction

    logic [CNT_W-1:0]    column_count_reg, column_count_next;
    logic [CNT_W-1:0]    row_count_reg, row_count_next;
    logic [ANCHOR_W-1:0] held_anchor_x_reg, held_anchor_y_reg;
    logic [SIZE_W-1:0]   held_width_reg, held_height_reg;
    logic [1:0]          held_mode_reg;
    logic [COLOR_W-1:0]  held_override_color_reg;

    logic                       accept;
    logic [CNT_W-1:0]           col, row;
    logic [ANCHOR_W-1:0]        ax_eff, ay_eff;
    logic [SIZE_W-1:0]          w_eff, h_eff;
    logic [1:0]                 mode_eff;
    logic [COLOR_W-1:0]         ovr_eff;
    logic signed [COORD_W-1:0]  ax_s, ay_s, w_s, h_s, col_s, row_s, x_s, y_s;
    logic                       on_screen;

    assign accept = push && !q_stat.full;

    // A first pixel uses its own geometry in the same cycle it is latched.
    always_comb
    begin
        if (first_pixel)
        begin
            ax_eff   = anchor_x;
            ay_eff   = anchor_y;
            w_eff    = clamp_size(sprite_width);
            h_eff    = clamp_size(sprite_height);
            mode_eff = {use_override, mirror};
            ovr_eff  = override_color;
            col      = '0;
            row      = '0;
        end
        else
        begin
            ax_eff   = held_anchor_x_reg;
            ay_eff   = held_anchor_y_reg;
            w_eff    = held_width_reg;
            h_eff    = held_height_reg;
            mode_eff = held_mode_reg;
            ovr_eff  = held_override_color_reg;
            col      = column_count_reg;
            row      = row_count_reg;
        end
    end

    always_comb
    begin
        ax_s  = COORD_W'($signed(ax_eff));
        ay_s  = COORD_W'($signed(ay_eff));
        w_s   = COORD_W'(w_eff);
        h_s   = COORD_W'(h_eff);
        col_s = COORD_W'(col);
        row_s = COORD_W'(row);
        if (mode_eff[0])
            x_s = ax_s - col_s;
        else
            x_s = ax_s - w_s + COORD_W'(1) + col_s;
        y_s = ay_s + h_s - COORD_W'(1) - row_s;
        on_screen = (x_s >= 0) && (x_s < X_LIM) && (y_s >= 0) && (y_s < Y_LIM);
    end

    // Advance in stored order, wrapping to the top-left after the last pixel.
    always_comb
    begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (accept)
        begin
            if (({1'b0, col} + SIZE_W'(1)) >= w_eff)
            begin
                column_count_next = '0;
                if (({1'b0, row} + SIZE_W'(1)) >= h_eff)
                    row_count_next = '0;
                else
                    row_count_next = row + CNT_W'(1);
            end
            else
            begin
                column_count_next = col + CNT_W'(1);
                row_count_next    = row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg        <= '0;
            row_count_reg           <= '0;
            held_anchor_x_reg       <= '0;
            held_anchor_y_reg       <= '0;
            held_width_reg          <= SIZE_W'(1);
            held_height_reg         <= SIZE_W'(1);
            held_mode_reg           <= '0;
            held_override_color_reg <= '0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            if (accept && first_pixel)
            begin
                held_anchor_x_reg       <= ax_eff;
                held_anchor_y_reg       <= ay_eff;
                held_width_reg          <= w_eff;
                held_height_reg         <= h_eff;
                held_mode_reg           <= mode_eff;
                held_override_color_reg <= ovr_eff;
            end
        end
    end

    // Drop transparent and off-screen pixels here; only drawable ones queue.
    assign q_push           = accept && on_screen && (pixel_code != transparent_code);
    assign q_data.code      = pixel_code;
    assign q_data.x         = x_s[X_W-1:0];
    assign q_data.y         = y_s[Y_W-1:0];
    assign q_data.ovr_en    = mode_eff[1];
    assign q_data.ovr_color = ovr_eff;

endmodule

// File: design/sbl_fifo.sv
// Short pixel queue between the front end and the back end.
`include "sprite_blit_led_matrix_macros.svh"

module sbl_fifo
    import sbl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  pix_t    wdata,
    input  logic    pop,
    output pix_t    rdata,
    output q_stat_t stat
);

    pix_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  do_push, do_pop;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rdata      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + FIFO_CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - FIFO_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    `SBL_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
    `SBL_ASSERT_NEXT(a_pop_only, clk, rst_n, do_pop && !do_push, count_reg == $past(count_reg) - FIFO_CNT_W'(1))
    `SBL_ASSERT_NEXT(a_push_only, clk, rst_n, do_push && !do_pop, count_reg == $past(count_reg) + FIFO_CNT_W'(1))

endmodule

// File: design/sbl_back.sv
// Back end: LED index, palette or override color, and the result register.
`include "sprite_blit_led_matrix_macros.svh"

module sbl_back
    import sbl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  q_stat_t            q_stat,
    input  pix_t               q_data,
    output logic               q_pop,
    input  palette_t           palette,
    input  logic               pop,
    output logic               empty,
    output logic [LED_W-1:0]   led_index,
    output logic [COLOR_W-1:0] led_color
);

    logic               valid_reg;
    logic [LED_W-1:0]   led_index_reg, led_index_next;
    logic [COLOR_W-1:0] led_color_reg, led_color_next;
    logic               load;

    // Refill the result register when it is free or being taken this cycle.
    assign load  = !q_stat.empty && (!valid_reg || pop);
    assign q_pop = load;

    always_comb
    begin
        led_index_next = LED_W'(LED_COUNT - 1)
                       - (LED_W'(q_data.x) * LED_W'(SCREEN_ROWS) + LED_W'(q_data.y));
        if (q_data.ovr_en)
            led_color_next = q_data.ovr_color;
        else
            led_color_next = palette[q_data.code];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (pop)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            led_index_reg <= led_index_next;
            led_color_reg <= led_color_next;
        end
    end

    assign empty     = !valid_reg;
    assign led_index = led_index_reg;
    assign led_color = led_color_reg;

    `SBL_ASSERT_NEXT(a_load_fills, clk, rst_n, load, !empty)
    `SBL_ASSERT_NEXT(a_drain, clk, rst_n, pop && !empty && q_stat.empty, empty)

endmodule
